// ===== sv/permutation_zscore_finalize_macros.svh =====
// assertion macros for the permutation z-score finalizer
`ifndef PERMUTATION_ZSCORE_FINALIZE_MACROS_SVH
`define PERMUTATION_ZSCORE_FINALIZE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PZF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define PZF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PZF_ASSERT_IMPL(lbl, ante, cons, msg)
`define PZF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/pzf_pkg.sv =====
// types and constants of the permutation z-score finalizer
`default_nettype none
package pzf_pkg;

  localparam int SUM_W       = 56;
  localparam int SQ_W        = 63;
  localparam int OBS_W       = 32;
  localparam int CNT_W       = 16;
  localparam int MEAN_W      = 32;
  localparam int VAR_W       = 48;
  localparam int P_W         = 25;
  localparam int Z_W         = 32;
  localparam int Z_FRAC      = 16;
  localparam int Z_INT       = Z_W - 1 - Z_FRAC;
  localparam int THR_W       = 25;
  localparam int DMAG_W      = SUM_W;
  localparam int CFG_W       = 25;
  localparam int IN_TDATA_W  = 168;
  localparam int OUT_TDATA_W = 144;
  localparam int NUM_PERM_RST = 1000;
  localparam int THR_RST      = 17;

  localparam logic [SUM_W-1:0] MAG_POS_MAX =
    {{(SUM_W-MEAN_W+1){1'b0}}, {(MEAN_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] MAG_NEG_MAX =
    {{(SUM_W-MEAN_W){1'b0}}, 1'b1, {(MEAN_W-1){1'b0}}};
  localparam logic [VAR_W-1:0] VAR_MAX = {VAR_W{1'b1}};

  typedef enum logic [1:0] {
    CFG_NUM_PERM = 2'd0,
    CFG_ZERO_THR = 2'd1,
    CFG_Z_EN     = 2'd2,
    CFG_P_EN     = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ZC_FINITE  = 2'd0,
    ZC_TINY    = 2'd1,
    ZC_POS_INF = 2'd2,
    ZC_NEG_INF = 2'd3
  } zcls_t;

  typedef enum logic [1:0] {
    VS_OK        = 2'd0,
    VS_SMALL_NEG = 2'd1,
    VS_LARGE_NEG = 2'd2
  } vstat_t;

  typedef struct packed {
    logic              last;
    logic              neg;
    logic [OBS_W-1:0]  obs;
  } a_side_t;

  typedef struct packed {
    logic              last;
    logic [MEAN_W-1:0] mean;
    logic [VAR_W-1:0]  var_v;
    vstat_t            vst;
    logic [P_W-1:0]    pv;
    logic              dneg;
    logic [DMAG_W-1:0] dmag;
  } b_side_t;

  typedef struct packed {
    b_side_t b;
    logic    small_sd;
    logic    sat;
  } c_side_t;

endpackage
`default_nettype wire

// ===== sv/permutation_zscore_finalize.sv =====
// Permutation test finalizer: mean, variance, p-value and z-score per matrix entry.
//
// Input beats carry one matrix entry each (sums of the permuted statistic, observed
// value, exceedance count); in_tlast marks the last entry of a batch. Every input beat
// gives exactly one output beat, in order, with out_tlast copied from in_tlast.
// The user must write configuration via cfg_we/cfg_addr/cfg_wdata only while no beat
// is in flight; the block does not enforce this. Throughput is one beat per cycle unless
// out_tready stalls the output. Stages: 63 cells of the mean, mean-square and p-value
// dividers, registers m1, m2 and m3 for squaring and variance, one cell per root bit of
// the square root chain, z1 setup, 31 z-score divider cells and the output register.
// All stages move together: when out_tready is low with a beat held at the output,
// the whole chain and in_tready stall until that beat is taken.
// Reset (rst_n low, synchronous) empties the pipeline and restores num_perm = 1000,
// zero_threshold = 17, z_enable = 1 and p_enable = 1.
`default_nettype none
`include "permutation_zscore_finalize_macros.svh"
module permutation_zscore_finalize #(
  parameter int FRAC_BITS       = 24,
  parameter int PERM_COUNT_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // sum_perm, sum_sq_perm, observed, exceed_count (lowest first), zero pad
  input  wire logic [pzf_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  wire logic                              in_tlast,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // mean_out, variance_out, p_value, z_score, z_class, var_status (lowest first), zero pad
  output logic      [pzf_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                                   out_tlast,
  input  wire logic                              cfg_we,
  input  wire logic [1:0]                        cfg_addr,
  input  wire logic [pzf_pkg::CFG_W-1:0]         cfg_wdata
);
  import pzf_pkg::*;

  localparam int F   = FRAC_BITS;
  localparam int NB  = PERM_COUNT_BITS;
  localparam int NA  = SQ_W;
  localparam int MB  = (64 + F + 1) / 2;
  localparam int H   = (MB + 1) / 2;
  localparam int PW  = 2 * MB;
  localparam int RB  = (VAR_W + F + 1) / 2;
  localparam int NZ  = Z_W - 1;
  localparam int MSQ_SH = 64 + F;
  localparam logic [SQ_W-1:0] P_ONE = SQ_W'(1) << F;

  // configuration
  logic [NB-1:0]    num_perm_r;
  logic [THR_W-1:0] thr_r;
  logic             z_en_r;
  logic             p_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_perm_r <= NB'(NUM_PERM_RST);
      thr_r      <= THR_W'(THR_RST);
      z_en_r     <= 1'b1;
      p_en_r     <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_NUM_PERM: num_perm_r <= cfg_wdata[NB-1:0];
        CFG_ZERO_THR: thr_r      <= cfg_wdata[THR_W-1:0];
        CFG_Z_EN:     z_en_r     <= cfg_wdata[0];
        CFG_P_EN:     p_en_r     <= cfg_wdata[0];
        default:      num_perm_r <= num_perm_r;
      endcase
    end
  end

  logic en;
  logic out_tvalid_r;
  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;

  // input unpacking and divider setup
  logic [SUM_W-1:0]    in_sum;
  logic [SUM_W-1:0]    in_mag;
  logic [NB-1:0]       n_eff;
  logic [NB:0]         np1;
  logic [NB+CNT_W-1:0] cnt_ext;
  logic [NB:0]         cp1;
  logic [SQ_W-1:0]     p_dvd;
  a_side_t             in_side;

  always_comb begin
    in_sum  = in_tdata[SUM_W-1:0];
    in_mag  = in_sum[SUM_W-1] ? (~in_sum + SUM_W'(1)) : in_sum;
    n_eff   = (num_perm_r == '0) ? NB'(1) : num_perm_r;
    np1     = {1'b0, n_eff} + (NB+1)'(1);
    cnt_ext = {{NB{1'b0}}, in_tdata[SUM_W+SQ_W+OBS_W +: CNT_W]};
    cp1     = {1'b0, cnt_ext[NB-1:0]} + (NB+1)'(1);
    p_dvd   = SQ_W'({cp1, {F{1'b0}}});
    in_side.last = in_tlast;
    in_side.neg  = in_sum[SUM_W-1];
    in_side.obs  = in_tdata[SUM_W+SQ_W +: OBS_W];
  end

  // first chain: three dividers side by side
  logic [NB-1:0]   lm_rem [0:NA];
  logic [SQ_W-1:0] lm_acc [0:NA];
  logic [NB-1:0]   lm_dvs [0:NA];
  logic [NB-1:0]   ls_rem [0:NA];
  logic [SQ_W-1:0] ls_acc [0:NA];
  logic [NB-1:0]   ls_dvs [0:NA];
  logic [NB:0]     lp_rem [0:NA];
  logic [SQ_W-1:0] lp_acc [0:NA];
  logic [NB:0]     lp_dvs [0:NA];
  logic            a_vld_r  [0:NA-1];
  a_side_t         a_side_r [0:NA-1];

  assign lm_rem[0] = '0;
  assign lm_acc[0] = SQ_W'(in_mag);
  assign lm_dvs[0] = n_eff;
  assign ls_rem[0] = '0;
  assign ls_acc[0] = in_tdata[SUM_W +: SQ_W];
  assign ls_dvs[0] = n_eff;
  assign lp_rem[0] = '0;
  assign lp_acc[0] = p_dvd;
  assign lp_dvs[0] = np1;

  for (genvar i = 0; i < NA; i++) begin : g_div_a
    pzf_div_cell #(.W(SQ_W), .K(NB)) u_mean (
      .clk(clk), .en(en),
      .rem_i(lm_rem[i]), .acc_i(lm_acc[i]), .dvs_i(lm_dvs[i]),
      .rem_o(lm_rem[i+1]), .acc_o(lm_acc[i+1]), .dvs_o(lm_dvs[i+1])
    );
    pzf_div_cell #(.W(SQ_W), .K(NB)) u_msq (
      .clk(clk), .en(en),
      .rem_i(ls_rem[i]), .acc_i(ls_acc[i]), .dvs_i(ls_dvs[i]),
      .rem_o(ls_rem[i+1]), .acc_o(ls_acc[i+1]), .dvs_o(ls_dvs[i+1])
    );
    pzf_div_cell #(.W(SQ_W), .K(NB+1)) u_pval (
      .clk(clk), .en(en),
      .rem_i(lp_rem[i]), .acc_i(lp_acc[i]), .dvs_i(lp_dvs[i]),
      .rem_o(lp_rem[i+1]), .acc_o(lp_acc[i+1]), .dvs_o(lp_dvs[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NA; i++) a_vld_r[i] <= 1'b0;
    end else if (en) begin
      a_vld_r[0] <= in_tvalid;
      for (int i = 1; i < NA; i++) a_vld_r[i] <= a_vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_side_r[0] <= in_side;
      for (int i = 1; i < NA; i++) a_side_r[i] <= a_side_r[i-1];
    end
  end

  // m1: signed mean, difference, partial squares, p clamp
  a_side_t             a_end;
  logic [SUM_W-1:0]    mmag;
  logic [MB-1:0]       msq_a;
  logic [H-1:0]        sq_lo;
  logic [MB-H-1:0]     sq_hi;
  logic [SUM_W:0]      mean_e;
  logic [SUM_W:0]      obs_e;
  logic [SUM_W:0]      diff;
  logic [SUM_W:0]      diff_n;
  logic [F:0]          p_c;
  logic [P_W+F:0]      p_ext;
  b_side_t             m1_b_nxt;

  always_comb begin
    a_end  = a_side_r[NA-1];
    mmag   = lm_acc[NA][SUM_W-1:0];
    msq_a  = mmag[MB-1:0];
    sq_lo  = msq_a[H-1:0];
    sq_hi  = msq_a[MB-1:H];
    mean_e = a_end.neg ? (~{1'b0, mmag} + (SUM_W+1)'(1)) : {1'b0, mmag};
    obs_e  = {{(SUM_W+1-OBS_W){a_end.obs[OBS_W-1]}}, a_end.obs};
    diff   = obs_e - mean_e;
    diff_n = ~diff + (SUM_W+1)'(1);
    p_c    = (lp_acc[NA] > P_ONE) ? P_ONE[F:0] : lp_acc[NA][F:0];
    p_ext  = {{P_W{1'b0}}, p_c};
    m1_b_nxt       = '0;
    m1_b_nxt.last  = a_end.last;
    if (!a_end.neg && (mmag > MAG_POS_MAX))
      m1_b_nxt.mean = {1'b0, {(MEAN_W-1){1'b1}}};
    else if (a_end.neg && (mmag > MAG_NEG_MAX))
      m1_b_nxt.mean = {1'b1, {(MEAN_W-1){1'b0}}};
    else
      m1_b_nxt.mean = mean_e[MEAN_W-1:0];
    m1_b_nxt.pv    = p_ext[P_W-1:0];
    m1_b_nxt.dneg  = diff[SUM_W];
    m1_b_nxt.dmag  = diff[SUM_W] ? diff_n[DMAG_W-1:0] : diff[DMAG_W-1:0];
  end

  logic                  m1_vld_r;
  b_side_t               m1_b_r;
  logic                  m1_ovf_r;
  logic [SQ_W-1:0]       m1_ms_r;
  logic [2*(MB-H)-1:0]   m1_hh_r;
  logic [MB-1:0]         m1_hl_r;
  logic [2*H-1:0]        m1_ll_r;

  always_ff @(posedge clk) begin
    if (en) begin
      m1_b_r   <= m1_b_nxt;
      m1_ovf_r <= |mmag[SUM_W-1:MB];
      m1_ms_r  <= ls_acc[NA];
      m1_hh_r  <= sq_hi * sq_hi;
      m1_hl_r  <= MB'(sq_hi * sq_lo);
      m1_ll_r  <= sq_lo * sq_lo;
    end
  end

  // m2: sum of partial squares
  logic            m2_vld_r;
  b_side_t         m2_b_r;
  logic            m2_ovf_r;
  logic [SQ_W-1:0] m2_ms_r;
  logic [PW-1:0]   m2_prod_r;
  logic [PW-1:0]   prod_nxt;

  assign prod_nxt = (PW'(m1_hh_r) << (2*H)) + (PW'(m1_hl_r) << (H+1)) + PW'(m1_ll_r);

  always_ff @(posedge clk) begin
    if (en) begin
      m2_b_r    <= m1_b_r;
      m2_ovf_r  <= m1_ovf_r;
      m2_ms_r   <= m1_ms_r;
      m2_prod_r <= prod_nxt;
    end
  end

  // m3: variance with clamp and status
  logic [PW-1:0] prod_sh;
  logic [63:0]   msq;
  logic [63:0]   ms64;
  logic [63:0]   vdiff;
  logic [63:0]   ndiff;
  logic          ovf;
  b_side_t       m3_b_nxt;

  always_comb begin
    prod_sh  = m2_prod_r >> F;
    msq      = prod_sh[63:0];
    ms64     = {1'b0, m2_ms_r};
    vdiff    = ms64 - msq;
    ndiff    = msq - ms64;
    ovf      = m2_ovf_r || ((m2_prod_r >> MSQ_SH) != '0);
    m3_b_nxt = m2_b_r;
    m3_b_nxt.var_v = '0;
    if (ovf) begin
      m3_b_nxt.vst = VS_LARGE_NEG;
    end else if (msq > ms64) begin
      m3_b_nxt.vst = (ndiff < 64'(thr_r)) ? VS_SMALL_NEG : VS_LARGE_NEG;
    end else begin
      m3_b_nxt.vst   = VS_OK;
      m3_b_nxt.var_v = (vdiff > 64'(VAR_MAX)) ? VAR_MAX : vdiff[VAR_W-1:0];
    end
  end

  logic    m3_vld_r;
  b_side_t m3_b_r;

  always_ff @(posedge clk) begin
    if (en) m3_b_r <= m3_b_nxt;
  end

  // square root chain
  logic [RB+1:0]   sq_rem  [0:RB];
  logic [RB-1:0]   sq_root [0:RB];
  logic [2*RB-1:0] sq_rad  [0:RB];
  logic            s_vld_r  [0:RB-1];
  b_side_t         s_side_r [0:RB-1];

  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_rad[0]  = (2*RB)'({m3_b_r.var_v, {F{1'b0}}});

  for (genvar i = 0; i < RB; i++) begin : g_sqrt
    pzf_sqrt_cell #(.RB(RB)) u_cell (
      .clk(clk), .en(en),
      .rem_i(sq_rem[i]), .root_i(sq_root[i]), .rad_i(sq_rad[i]),
      .rem_o(sq_rem[i+1]), .root_o(sq_root[i+1]), .rad_o(sq_rad[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_side_r[0] <= m3_b_r;
      for (int i = 1; i < RB; i++) s_side_r[i] <= s_side_r[i-1];
    end
  end

  // z1: tiny deviation and saturation checks, divider setup
  b_side_t          s_end;
  logic [RB-1:0]    sd;
  logic [DMAG_W-1:0] dsh;
  c_side_t          z1_side_nxt;

  always_comb begin
    s_end = s_side_r[RB-1];
    sd    = sq_root[RB];
    dsh   = s_end.dmag >> Z_INT;
    z1_side_nxt.b        = s_end;
    z1_side_nxt.small_sd = (sd == '0) || (sd < RB'(thr_r));
    z1_side_nxt.sat      = dsh >= DMAG_W'(sd);
  end

  logic          z1_vld_r;
  c_side_t       z1_side_r;
  logic [RB-1:0] z1_rem_r;
  logic [NZ-1:0] z1_acc_r;
  logic [RB-1:0] z1_sd_r;

  always_ff @(posedge clk) begin
    if (en) begin
      z1_side_r <= z1_side_nxt;
      z1_rem_r  <= dsh[RB-1:0];
      z1_acc_r  <= {s_end.dmag[Z_INT-1:0], {Z_FRAC{1'b0}}};
      z1_sd_r   <= sd;
    end
  end

  // z-score divider chain
  logic [RB-1:0] zd_rem [0:NZ];
  logic [NZ-1:0] zd_acc [0:NZ];
  logic [RB-1:0] zd_dvs [0:NZ];
  logic          zc_vld_r  [0:NZ-1];
  c_side_t       zc_side_r [0:NZ-1];

  assign zd_rem[0] = z1_rem_r;
  assign zd_acc[0] = z1_acc_r;
  assign zd_dvs[0] = z1_sd_r;

  for (genvar i = 0; i < NZ; i++) begin : g_div_z
    pzf_div_cell #(.W(NZ), .K(RB)) u_cell (
      .clk(clk), .en(en),
      .rem_i(zd_rem[i]), .acc_i(zd_acc[i]), .dvs_i(zd_dvs[i]),
      .rem_o(zd_rem[i+1]), .acc_o(zd_acc[i+1]), .dvs_o(zd_dvs[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zc_side_r[0] <= z1_side_r;
      for (int i = 1; i < NZ; i++) zc_side_r[i] <= zc_side_r[i-1];
    end
  end

  // valid bits for the stages after the first chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r <= 1'b0;
      m2_vld_r <= 1'b0;
      m3_vld_r <= 1'b0;
      z1_vld_r <= 1'b0;
      for (int i = 0; i < RB; i++) s_vld_r[i] <= 1'b0;
      for (int i = 0; i < NZ; i++) zc_vld_r[i] <= 1'b0;
    end else if (en) begin
      m1_vld_r   <= a_vld_r[NA-1];
      m2_vld_r   <= m1_vld_r;
      m3_vld_r   <= m2_vld_r;
      s_vld_r[0] <= m3_vld_r;
      for (int i = 1; i < RB; i++) s_vld_r[i] <= s_vld_r[i-1];
      z1_vld_r    <= s_vld_r[RB-1];
      zc_vld_r[0] <= z1_vld_r;
      for (int i = 1; i < NZ; i++) zc_vld_r[i] <= zc_vld_r[i-1];
    end
  end

  // final: sign, saturation, class and enables
  c_side_t        z_end;
  logic [Z_W-1:0] zmag;
  logic [Z_W-1:0] z_nxt;
  zcls_t          zcls_nxt;
  logic [P_W-1:0] p_nxt;
  logic           dpos;

  always_comb begin
    z_end    = zc_side_r[NZ-1];
    zmag     = z_end.sat ? {1'b1, {(Z_W-1){1'b0}}} : {1'b0, zd_acc[NZ]};
    dpos     = !z_end.b.dneg && (z_end.b.dmag != '0);
    z_nxt    = '0;
    zcls_nxt = ZC_FINITE;
    if (z_en_r) begin
      if (z_end.small_sd) begin
        if (z_end.b.dmag < DMAG_W'(thr_r)) zcls_nxt = ZC_TINY;
        else if (dpos)                     zcls_nxt = ZC_POS_INF;
        else                               zcls_nxt = ZC_NEG_INF;
      end else if (z_end.b.dneg) begin
        z_nxt = ~zmag + Z_W'(1);
      end else begin
        z_nxt = z_end.sat ? {1'b0, {(Z_W-1){1'b1}}} : zmag;
      end
    end
    p_nxt = p_en_r ? z_end.b.pv : '0;
  end

  logic [MEAN_W-1:0] out_mean_r;
  logic [VAR_W-1:0]  out_var_r;
  logic [P_W-1:0]    out_p_r;
  logic [Z_W-1:0]    out_z_r;
  zcls_t             out_zcls_r;
  vstat_t            out_vst_r;
  logic              out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_tvalid_r <= 1'b0;
    else if (en) out_tvalid_r <= zc_vld_r[NZ-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_mean_r <= z_end.b.mean;
      out_var_r  <= z_end.b.var_v;
      out_p_r    <= p_nxt;
      out_z_r    <= z_nxt;
      out_zcls_r <= zcls_nxt;
      out_vst_r  <= z_end.b.vst;
      out_last_r <= z_end.b.last;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {3'b000, out_vst_r, out_zcls_r, out_z_r, out_p_r, out_var_r,
                       out_mean_r};

  `PZF_ASSERT_IMPL(a_cls_no_z, out_tvalid_r && (out_zcls_r != ZC_FINITE), out_z_r == '0, "z_score nonzero with non-finite class")
  `PZF_ASSERT_IMPL(a_neg_var_zero, out_tvalid_r && (out_vst_r != VS_OK), out_var_r == '0, "clamped variance not zero")
  `PZF_ASSERT_IMPL(a_z_off, out_tvalid_r && !z_en_r, (out_zcls_r == ZC_FINITE) && (out_z_r == '0), "z fields set while disabled")
  `PZF_ASSERT_NEXT(a_drain, en && zc_vld_r[NZ-1], out_tvalid_r, "finished beat did not reach the output")

endmodule
`default_nettype wire

// ===== sv/pzf_div_cell.sv =====
// one restoring division step per cell, registered
`default_nettype none
module pzf_div_cell #(
  parameter int W = 8,
  parameter int K = 8
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [K-1:0] rem_i,
  input  wire logic [W-1:0] acc_i,
  input  wire logic [K-1:0] dvs_i,
  output logic      [K-1:0] rem_o,
  output logic      [W-1:0] acc_o,
  output logic      [K-1:0] dvs_o
);

  logic [K:0]   trial;
  logic [K:0]   diff;
  logic         ge;
  logic [K-1:0] rem_nxt;
  logic [W-1:0] acc_nxt;
  logic [K-1:0] rem_r;
  logic [W-1:0] acc_r;
  logic [K-1:0] dvs_r;

  always_comb begin
    trial   = {rem_i, acc_i[W-1]};
    ge      = trial >= {1'b0, dvs_i};
    diff    = trial - {1'b0, dvs_i};
    rem_nxt = ge ? diff[K-1:0] : trial[K-1:0];
    acc_nxt = {acc_i[W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      acc_r <= acc_nxt;
      dvs_r <= dvs_i;
    end
  end

  assign rem_o = rem_r;
  assign acc_o = acc_r;
  assign dvs_o = dvs_r;

endmodule
`default_nettype wire

// ===== sv/pzf_sqrt_cell.sv =====
// one digit-by-digit square root step per cell, registered
`default_nettype none
module pzf_sqrt_cell #(
  parameter int RB = 8
) (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [RB+1:0]     rem_i,
  input  wire logic [RB-1:0]     root_i,
  input  wire logic [2*RB-1:0]   rad_i,
  output logic      [RB+1:0]     rem_o,
  output logic      [RB-1:0]     root_o,
  output logic      [2*RB-1:0]   rad_o
);

  logic [RB+3:0]   cur;
  logic [RB+3:0]   trial;
  logic [RB+3:0]   diff;
  logic            ge;
  logic [RB+1:0]   rem_nxt;
  logic [RB-1:0]   root_nxt;
  logic [2*RB-1:0] rad_nxt;
  logic [RB+1:0]   rem_r;
  logic [RB-1:0]   root_r;
  logic [2*RB-1:0] rad_r;

  always_comb begin
    cur      = {rem_i, rad_i[2*RB-1:2*RB-2]};
    trial    = {2'b00, root_i, 2'b01};
    ge       = cur >= trial;
    diff     = cur - trial;
    rem_nxt  = ge ? diff[RB+1:0] : cur[RB+1:0];
    root_nxt = {root_i[RB-2:0], ge};
    rad_nxt  = {rad_i[2*RB-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      rad_r  <= rad_nxt;
    end
  end

  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign rad_o  = rad_r;

endmodule
`default_nettype wire
